### hw/rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Types, constants and codes shared by the button click event detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // register indexes
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_MS  = 2'd1;
    localparam logic [1:0] REG_LONG_MS      = 2'd2;
    localparam logic [1:0] REG_CLICK_MS     = 2'd3;

    localparam logic             RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG_MS      = 16'd1000;
    localparam logic [CFG_W-1:0] RST_CLICK_MS     = 16'd300;

    // state codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DEBOUNCE = 3'd1;
    localparam logic [2:0] ST_PRESSED  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_DOUBLE   = 3'd4;
    localparam logic [2:0] ST_WAIT     = 3'd5;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_CLICK  = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    typedef struct packed {
        logic             active_level;
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] click_ms;
    } bcd_cfg_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic       debounced_pressed;
    } bcd_result_t;

    typedef struct packed {
        logic        push;
        bcd_result_t result;
    } bcd_push_t;

endpackage

### hw/rtl/bcd_if.sv
// ----------------------------------------------------------------------------
// bcd_in_if / bcd_out_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface bcd_in_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);
endinterface

interface bcd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       debounced_pressed;

    modport source (output valid, output event_code, output debounced_pressed, input ready);
    modport sink   (input valid, input event_code, input debounced_pressed, output ready);
endinterface

### hw/rtl/bcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcd_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module bcd_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]   cfg_data,
    output bcd_pkg::bcd_cfg_t           cfg
);
    import bcd_pkg::*;

    bcd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level  <= RST_ACTIVE_LEVEL;
            cfg_reg.debounce_ms   <= RST_DEBOUNCE_MS;
            cfg_reg.long_press_ms <= RST_LONG_MS;
            cfg_reg.click_ms      <= RST_CLICK_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_LEVEL: cfg_reg.active_level  <= cfg_data[0];
                REG_DEBOUNCE_MS:  cfg_reg.debounce_ms   <= cfg_data;
                REG_LONG_MS:      cfg_reg.long_press_ms <= cfg_data;
                REG_CLICK_MS:     cfg_reg.click_ms      <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/bcd_fsm.sv
// ----------------------------------------------------------------------------
// bcd_fsm
// Input register, debounce and click state machine with saturating timers.
// ----------------------------------------------------------------------------
module bcd_fsm
(
    input  logic               clk,
    input  logic               rst_n,
    input  bcd_pkg::bcd_cfg_t  cfg,
    input  logic               in_valid,
    input  logic               in_raw_level,
    output logic               in_ready,
    input  logic               res_space,
    output bcd_pkg::bcd_push_t res
);
    import bcd_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_level_reg;
    logic [2:0]            state_reg, state_next;
    logic [2:0]            succ_reg, succ_next;
    logic [2:0]            fail_reg, fail_next;
    logic [TIMER_BITS-1:0] deb_reg, deb_next;
    logic [TIMER_BITS-1:0] since_reg, since_next;
    logic                  pflag_reg, pflag_next;

    logic                  advance;
    logic                  pressed;
    logic [TIMER_BITS-1:0] deb_inc, since_inc;
    logic [1:0]            ev;

    assign advance  = s1_valid_reg && res_space;
    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_level_reg <= in_raw_level;
        end
    end

    assign pressed   = (s1_level_reg == cfg.active_level);
    assign deb_inc   = (deb_reg == TIMER_MAX) ? deb_reg : deb_reg + 1'b1;
    assign since_inc = (since_reg == TIMER_MAX) ? since_reg : since_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        succ_next  = succ_reg;
        fail_next  = fail_reg;
        deb_next   = deb_inc;
        since_next = since_inc;
        pflag_next = pflag_reg;
        ev         = EV_NONE;
        case (state_reg)
            ST_DEBOUNCE:
            begin
                if (pressed == pflag_reg)
                begin
                    state_next = fail_reg;
                end
                else if (CMP_W'(deb_inc) >= CMP_W'(cfg.debounce_ms))
                begin
                    since_next = '0;
                    pflag_next = !pflag_reg;
                    state_next = succ_reg;
                end
            end
            ST_PRESSED:
            begin
                if (!pressed)
                begin
                    state_next = ST_DEBOUNCE;
                    succ_next  = ST_RELEASED;
                    fail_next  = ST_PRESSED;
                    deb_next   = '0;
                end
                else if (CMP_W'(since_inc) >= CMP_W'(cfg.long_press_ms))
                begin
                    ev         = EV_LONG;
                    state_next = ST_WAIT;
                end
            end
            ST_RELEASED:
            begin
                if (pressed)
                begin
                    state_next = ST_DEBOUNCE;
                    succ_next  = ST_DOUBLE;
                    fail_next  = ST_RELEASED;
                    deb_next   = '0;
                end
                else if (CMP_W'(since_inc) >= CMP_W'(cfg.click_ms))
                begin
                    ev         = EV_CLICK;
                    state_next = ST_IDLE;
                end
            end
            ST_DOUBLE:
            begin
                ev         = EV_DOUBLE;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!pressed)
                begin
                    state_next = ST_DEBOUNCE;
                    succ_next  = ST_IDLE;
                    fail_next  = ST_WAIT;
                    deb_next   = '0;
                end
            end
            default:
            begin
                // unused codes behave as idle
                if (pressed)
                begin
                    state_next = ST_DEBOUNCE;
                    succ_next  = ST_PRESSED;
                    fail_next  = ST_IDLE;
                    deb_next   = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            succ_reg  <= ST_IDLE;
            fail_reg  <= ST_IDLE;
            deb_reg   <= '0;
            since_reg <= '0;
            pflag_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            succ_reg  <= succ_next;
            fail_reg  <= fail_next;
            deb_reg   <= deb_next;
            since_reg <= since_next;
            pflag_reg <= pflag_next;
        end
    end

    assign res.push                     = advance;
    assign res.result.event_code        = ev;
    assign res.result.debounced_pressed = pflag_next;

    // the debounced level only flips on leaving debounce
    a_pflag_from_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (pflag_reg != $past(pflag_reg)) |-> ($past(state_reg) == ST_DEBOUNCE))
        else $error("debounced level changed outside debounce");

    // long press and double click both lead to wait for release
    a_wait_after_event: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (ev == EV_LONG || ev == EV_DOUBLE)) |=> (state_reg == ST_WAIT))
        else $error("no wait for release after long press or double click");

    // a click always returns to idle
    a_idle_after_click: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ev == EV_CLICK) |=> (state_reg == ST_IDLE))
        else $error("click did not return to idle");

    // timers only move when an item is processed
    a_timers_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(deb_reg) && $stable(since_reg) && $stable(state_reg)))
        else $error("state moved without an item");

endmodule

### hw/rtl/bcd_out_buf.sv
// ----------------------------------------------------------------------------
// bcd_out_buf
// Two-entry result buffer; space flag is registered so input ready does not
// depend on output ready.
// ----------------------------------------------------------------------------
module bcd_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcd_pkg::bcd_push_t   res,
    output logic                 res_space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bcd_pkg::bcd_result_t out_result
);
    import bcd_pkg::*;

    bcd_result_t mem_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        head_reg, head_next;
    logic        pop;
    logic        wr_idx;

    assign out_valid  = (count_reg != 2'd0);
    assign pop        = out_valid && out_ready;
    assign res_space  = (count_reg != 2'd2);
    assign wr_idx     = head_reg ^ count_reg[0];
    assign out_result = mem_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        case ({res.push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:
            begin
                count_next = count_reg - 2'd1;
                head_next  = !head_reg;
            end
            2'b11:   head_next = !head_reg;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            mem_reg[wr_idx] <= res.result;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !res.push)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // a waiting result stays at the head until taken
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(head_reg))
        else $error("head moved while result stalled");

endmodule

### hw/rtl/button_click_event_detector_core.sv
// ----------------------------------------------------------------------------
// button_click_event_detector_core
// Debounced button event detector: click, double click and long press.
// ----------------------------------------------------------------------------
// channel  dir  payload                         role
// in_ch    in   raw_level                       one item per millisecond tick
// out_ch   out  event_code, debounced_pressed   one result item per tick item
// cfg      in   cfg_we, cfg_index, cfg_data     register writes, no read-back
//
// one item per cycle unless the result buffer is full; results are registered
// the state update per tick is one pass through the state machine logic
// reset clears state, timers and buffers; registers return to their defaults
// a two-entry result buffer keeps input ready free of output ready
// when the buffer is full the input register holds and input ready drops
// ----------------------------------------------------------------------------
module button_click_event_detector_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    bcd_in_if.sink                    in_ch,
    bcd_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0] cfg_data
);
    import bcd_pkg::*;

    bcd_cfg_t    cfg;
    bcd_push_t   res;
    logic        res_space;
    bcd_result_t out_result;

    bcd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcd_fsm u_fsm
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_ch.valid),
        .in_raw_level (in_ch.raw_level),
        .in_ready     (in_ch.ready),
        .res_space    (res_space),
        .res          (res)
    );

    bcd_out_buf u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_space  (res_space),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_result (out_result)
    );

    assign out_ch.event_code        = out_result.event_code;
    assign out_ch.debounced_pressed = out_result.debounced_pressed;

endmodule
